[rtl/core/rrcp_pkg.sv]
// shared constants, types and functions for the rotated rectangle corner placer
// builds the quarter-wave sine table at elaboration; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrcp_pkg;

    localparam int COORD_FRAC_BITS        = 4;
    localparam int ANGLE_STEPS_PER_DEGREE = 4;
    localparam int SINE_FRAC_BITS         = 15;

    localparam int QUARTER_STEPS = 90 * ANGLE_STEPS_PER_DEGREE;
    localparam int FULL_STEPS    = 360 * ANGLE_STEPS_PER_DEGREE;

    // field widths
    localparam int REQ_W    = 13;
    localparam int ANGLE_W  = 11;
    localparam int POS_W    = 11;
    localparam int SIZE_W   = 10;
    localparam int LIMIT_W  = 11;
    localparam int COORD_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // derived widths
    localparam int PIX_W    = COORD_W - COORD_FRAC_BITS;
    localparam int CENTER_W = ((PIX_W > POS_W) ? PIX_W : POS_W) + 1;
    localparam int SINE_W   = SINE_FRAC_BITS + 1;
    localparam int SSINE_W  = SINE_W + 1;
    localparam int PROD_W   = SIZE_W + 1 + SSINE_W;
    localparam int V_W      = (((CENTER_W + SINE_W + 1) > PROD_W) ?
                               (CENTER_W + SINE_W + 1) : PROD_W) + 2;
    localparam int ROM_DEPTH = QUARTER_STEPS + 1;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam int ROUND_SHIFT = SINE_FRAC_BITS + 1 - COORD_FRAC_BITS;
    localparam int ROUND_BIAS  = 1 << (SINE_FRAC_BITS - COORD_FRAC_BITS);

    localparam int NUM_CORNER_COORDS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0]  RECT_WIDTH_RST   = 10'd16;
    localparam logic [SIZE_W-1:0]  RECT_HEIGHT_RST  = 10'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_WIDTH_RST  = 11'd2047;
    localparam logic [LIMIT_W-1:0] LIMIT_HEIGHT_RST = 11'd2047;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                              64'd42, 64'd20, 64'd6};

    // order TLx TLy TRx TRy BLx BLy BRx BRy
    typedef logic [NUM_CORNER_COORDS-1:0][COORD_W-1:0] corner_set_t;

    typedef logic [SINE_W-1:0] sine_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic              neg;
        logic [ROM_AW-1:0] idx;
    } rom_sel_t;

    typedef struct packed {
        logic        ok;
        corner_set_t coords;
    } place_result_t;

    function automatic logic [SINE_W-1:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (64'(k) * HALF_PI_Q30) / QUARTER_STEPS;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 6; i++)
        begin
            t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[i];
        end
        s = (x * t) >> 30;
        r = (s + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
        if (r > (64'd1 << SINE_FRAC_BITS))
        begin
            r = 64'd1 << SINE_FRAC_BITS;
        end
        return r[SINE_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    // quadrant fold of an angle in 0 .. FULL_STEPS-1 onto the table
    function automatic rom_sel_t rom_select(input logic [ANGLE_W-1:0] a);
        rom_sel_t            sel;
        logic [ANGLE_W-1:0]  rem;
        logic                odd;
        if (a >= ANGLE_W'(3 * QUARTER_STEPS))
        begin
            rem     = a - ANGLE_W'(3 * QUARTER_STEPS);
            odd     = 1'b1;
            sel.neg = 1'b1;
        end
        else if (a >= ANGLE_W'(2 * QUARTER_STEPS))
        begin
            rem     = a - ANGLE_W'(2 * QUARTER_STEPS);
            odd     = 1'b0;
            sel.neg = 1'b1;
        end
        else if (a >= ANGLE_W'(QUARTER_STEPS))
        begin
            rem     = a - ANGLE_W'(QUARTER_STEPS);
            odd     = 1'b1;
            sel.neg = 1'b0;
        end
        else
        begin
            rem     = a;
            odd     = 1'b0;
            sel.neg = 1'b0;
        end
        if (odd)
        begin
            sel.idx = ROM_AW'(ANGLE_W'(QUARTER_STEPS) - rem);
        end
        else
        begin
            sel.idx = ROM_AW'(rem);
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rrcp_sine_rom.sv]
// quarter-wave sine table with two registered read ports
// depends on rrcp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrcp_sine_rom (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [rrcp_pkg::ROM_AW-1:0]  sin_addr,
    input  wire logic [rrcp_pkg::ROM_AW-1:0]  cos_addr,
    output logic      [rrcp_pkg::SINE_W-1:0]  sin_mag,
    output logic      [rrcp_pkg::SINE_W-1:0]  cos_mag
);
    import rrcp_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [SINE_W-1:0] sin_reg;
    logic [SINE_W-1:0] cos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= SINE_ROM[sin_addr];
            cos_reg <= SINE_ROM[cos_addr];
        end
    end

    assign sin_mag = sin_reg;
    assign cos_mag = cos_reg;

endmodule

`default_nettype wire

[rtl/core/rrcp_corner_calc.sv]
// center selection, corner sums, rounding and limit check for one request
// depends on rrcp_pkg; purely combinational
`timescale 1ns / 1ps
`default_nettype none

module rrcp_corner_calc (
    input  wire rrcp_pkg::corner_set_t              corners,
    input  wire logic                               center_given,
    input  wire logic [rrcp_pkg::POS_W-1:0]         center_x,
    input  wire logic [rrcp_pkg::POS_W-1:0]         center_y,
    input  wire logic signed [rrcp_pkg::PROD_W-1:0] wc,
    input  wire logic signed [rrcp_pkg::PROD_W-1:0] ws,
    input  wire logic signed [rrcp_pkg::PROD_W-1:0] hc,
    input  wire logic signed [rrcp_pkg::PROD_W-1:0] hs,
    input  wire logic [rrcp_pkg::LIMIT_W-1:0]       limit_width,
    input  wire logic [rrcp_pkg::LIMIT_W-1:0]       limit_height,
    output rrcp_pkg::place_result_t                 result
);
    import rrcp_pkg::*;

    logic [PIX_W-1:0]           lo [2];
    logic [PIX_W-1:0]           hi [2];
    logic [PIX_W-1:0]           p;
    logic [CENTER_W-1:0]        derived [2];
    logic [CENTER_W-1:0]        cx_sel;
    logic [CENTER_W-1:0]        cy_sel;
    logic signed [V_W-1:0]      cxs;
    logic signed [V_W-1:0]      cys;
    logic signed [V_W-1:0]      ewc;
    logic signed [V_W-1:0]      ews;
    logic signed [V_W-1:0]      ehc;
    logic signed [V_W-1:0]      ehs;
    logic signed [V_W-1:0]      v [NUM_CORNER_COORDS];
    logic [V_W-1:0]             rounded;
    logic [V_W-1:0]             lim;

    // per-axis min and max over the stored corners in whole pixels
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            lo[ax] = corners[ax][COORD_W-1:COORD_FRAC_BITS];
            hi[ax] = lo[ax];
            for (int c = 1; c < 4; c++)
            begin
                p = corners[2 * c + ax][COORD_W-1:COORD_FRAC_BITS];
                if (p < lo[ax])
                begin
                    lo[ax] = p;
                end
                if (p > hi[ax])
                begin
                    hi[ax] = p;
                end
            end
            derived[ax] = CENTER_W'(lo[ax]) + CENTER_W'((hi[ax] - lo[ax]) >> 1)
                          + CENTER_W'(1);
        end
    end

    assign cx_sel = center_given ? CENTER_W'(center_x) : derived[0];
    assign cy_sel = center_given ? CENTER_W'(center_y) : derived[1];

    assign cxs = $signed(V_W'({cx_sel, {SINE_W{1'b0}}}));
    assign cys = $signed(V_W'({cy_sel, {SINE_W{1'b0}}}));
    assign ewc = V_W'(wc);
    assign ews = V_W'(ws);
    assign ehc = V_W'(hc);
    assign ehs = V_W'(hs);

    assign v[0] = cxs - ewc + ehs;
    assign v[1] = cys - ehc - ews;
    assign v[2] = cxs + ewc + ehs;
    assign v[3] = cys - ehc + ews;
    assign v[4] = cxs - ewc - ehs;
    assign v[5] = cys + ehc - ews;
    assign v[6] = cxs + ewc - ehs;
    assign v[7] = cys + ehc + ews;

    always_comb
    begin
        result.ok     = 1'b1;
        result.coords = '0;
        for (int i = 0; i < NUM_CORNER_COORDS; i++)
        begin
            rounded = (V_W'(v[i]) + V_W'(ROUND_BIAS)) >> ROUND_SHIFT;
            if ((i % 2) == 1)
            begin
                lim = V_W'({limit_height, {COORD_FRAC_BITS{1'b0}}});
            end
            else
            begin
                lim = V_W'({limit_width, {COORD_FRAC_BITS{1'b0}}});
            end
            if (v[i][V_W-1] || (rounded >= lim))
            begin
                result.ok = 1'b0;
            end
            result.coords[i] = rounded[COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/core/rotated_rect_corner_placer.sv]
// top level of the rotated rectangle corner placer: config registers,
// three-stage pipeline with handshake, stored placement
// depends on rrcp_pkg, rrcp_sine_rom, rrcp_corner_calc
//
// usage
//   in channel: in_valid/in_ready with angle_request, center_given, center_x,
//   center_y. out channel: out_valid/out_ready with accepted, angle_now and
//   the eight corner coordinates; corners and angle are the stored placement
//   after the request (unchanged when accepted is 0).
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no beat is in flight.
//   path: table read, products, corner sums and limit check, each stage
//   registered. throughput: one beat per cycle while out_ready is high.
//   the placement feeds back into the derived center of the next request
//   through the stored corner registers, updated as each accepted result loads.
//   reset: corners and angle zero, size 16x16, limits 2047, pipeline empty.
//   receiver stall: the result beat holds, the stages behind it keep
//   filling until full, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rotated_rect_corner_placer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rrcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rrcp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [rrcp_pkg::REQ_W-1:0] angle_request,
    input  wire logic                              center_given,
    input  wire logic [rrcp_pkg::POS_W-1:0]        center_x,
    input  wire logic [rrcp_pkg::POS_W-1:0]        center_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   accepted,
    output logic [rrcp_pkg::ANGLE_W-1:0]           angle_now,
    output logic [rrcp_pkg::COORD_W-1:0]           top_left_x,
    output logic [rrcp_pkg::COORD_W-1:0]           top_left_y,
    output logic [rrcp_pkg::COORD_W-1:0]           top_right_x,
    output logic [rrcp_pkg::COORD_W-1:0]           top_right_y,
    output logic [rrcp_pkg::COORD_W-1:0]           bottom_left_x,
    output logic [rrcp_pkg::COORD_W-1:0]           bottom_left_y,
    output logic [rrcp_pkg::COORD_W-1:0]           bottom_right_x,
    output logic [rrcp_pkg::COORD_W-1:0]           bottom_right_y
);
    import rrcp_pkg::*;

    // configuration
    logic [SIZE_W-1:0]  rect_width_reg;
    logic [SIZE_W-1:0]  rect_height_reg;
    logic [LIMIT_W-1:0] limit_width_reg;
    logic [LIMIT_W-1:0] limit_height_reg;

    // stage a: normalized angle, table read
    logic                 a_valid_reg;
    logic [ANGLE_W-1:0]   a_angle_reg;
    logic                 a_given_reg;
    logic [POS_W-1:0]     a_cx_reg;
    logic [POS_W-1:0]     a_cy_reg;
    logic                 a_sin_neg_reg;
    logic                 a_cos_neg_reg;
    logic [SINE_W-1:0]    sin_mag;
    logic [SINE_W-1:0]    cos_mag;

    // stage b: products
    logic                      b_valid_reg;
    logic [ANGLE_W-1:0]        b_angle_reg;
    logic                      b_given_reg;
    logic [POS_W-1:0]          b_cx_reg;
    logic [POS_W-1:0]          b_cy_reg;
    logic signed [PROD_W-1:0]  b_wc_reg;
    logic signed [PROD_W-1:0]  b_ws_reg;
    logic signed [PROD_W-1:0]  b_hc_reg;
    logic signed [PROD_W-1:0]  b_hs_reg;

    // result and stored placement
    logic                 out_valid_reg;
    logic                 accepted_reg;
    corner_set_t          corner_reg;
    logic [ANGLE_W-1:0]   angle_reg;

    logic                 a_ready;
    logic                 b_ready;
    logic                 c_ready;
    logic                 in_fire;

    logic signed [REQ_W:0]   req_ext;
    logic signed [REQ_W:0]   req_wrap;
    logic [ANGLE_W-1:0]      angle_next;
    logic [ANGLE_W:0]        cos_sum;
    logic [ANGLE_W-1:0]      cos_angle;
    rom_sel_t                sin_sel;
    rom_sel_t                cos_sel;

    logic signed [SSINE_W-1:0] sin_val;
    logic signed [SSINE_W-1:0] cos_val;
    logic signed [SIZE_W:0]    w_s;
    logic signed [SIZE_W:0]    h_s;

    place_result_t        calc;

    assign c_ready  = !out_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign in_fire  = in_valid && a_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_width_reg   <= RECT_WIDTH_RST;
            rect_height_reg  <= RECT_HEIGHT_RST;
            limit_width_reg  <= LIMIT_WIDTH_RST;
            limit_height_reg <= LIMIT_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RECT_WIDTH:   rect_width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_RECT_HEIGHT:  rect_height_reg  <= cfg_data[SIZE_W-1:0];
                CFG_LIMIT_WIDTH:  limit_width_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_HEIGHT: limit_height_reg <= cfg_data[LIMIT_W-1:0];
                default:          rect_width_reg   <= rect_width_reg;
            endcase
        end
    end

    // angle normalization and quadrant fold
    assign req_ext  = {angle_request[REQ_W-1], angle_request};
    assign req_wrap = req_ext + (REQ_W + 1)'(FULL_STEPS);

    always_comb
    begin
        if (req_ext >= $signed((REQ_W + 1)'(FULL_STEPS)))
        begin
            angle_next = '0;
        end
        else if (req_ext < 0)
        begin
            if (req_wrap < 0)
            begin
                angle_next = '0;
            end
            else
            begin
                angle_next = req_wrap[ANGLE_W-1:0];
            end
        end
        else
        begin
            angle_next = req_ext[ANGLE_W-1:0];
        end
    end

    assign cos_sum   = (ANGLE_W + 1)'(angle_next) + (ANGLE_W + 1)'(QUARTER_STEPS);
    assign cos_angle = (cos_sum >= (ANGLE_W + 1)'(FULL_STEPS)) ?
                       ANGLE_W'(cos_sum - (ANGLE_W + 1)'(FULL_STEPS)) :
                       cos_sum[ANGLE_W-1:0];
    assign sin_sel   = rom_select(angle_next);
    assign cos_sel   = rom_select(cos_angle);

    rrcp_sine_rom u_sine_rom (
        .clk      (clk),
        .en       (in_fire),
        .sin_addr (sin_sel.idx),
        .cos_addr (cos_sel.idx),
        .sin_mag  (sin_mag),
        .cos_mag  (cos_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_angle_reg   <= angle_next;
            a_given_reg   <= center_given;
            a_cx_reg      <= center_x;
            a_cy_reg      <= center_y;
            a_sin_neg_reg <= sin_sel.neg;
            a_cos_neg_reg <= cos_sel.neg;
        end
    end

    // signed sine and cosine, size products
    assign sin_val = a_sin_neg_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign cos_val = a_cos_neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    assign w_s     = $signed({1'b0, rect_width_reg});
    assign h_s     = $signed({1'b0, rect_height_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_angle_reg <= a_angle_reg;
            b_given_reg <= a_given_reg;
            b_cx_reg    <= a_cx_reg;
            b_cy_reg    <= a_cy_reg;
            b_wc_reg    <= PROD_W'(w_s * cos_val);
            b_ws_reg    <= PROD_W'(w_s * sin_val);
            b_hc_reg    <= PROD_W'(h_s * cos_val);
            b_hs_reg    <= PROD_W'(h_s * sin_val);
        end
    end

    rrcp_corner_calc u_corner_calc (
        .corners      (corner_reg),
        .center_given (b_given_reg),
        .center_x     (b_cx_reg),
        .center_y     (b_cy_reg),
        .wc           (b_wc_reg),
        .ws           (b_ws_reg),
        .hc           (b_hc_reg),
        .hs           (b_hs_reg),
        .limit_width  (limit_width_reg),
        .limit_height (limit_height_reg),
        .result       (calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            corner_reg    <= '0;
            angle_reg     <= '0;
        end
        else if (c_ready)
        begin
            out_valid_reg <= b_valid_reg;
            if (b_valid_reg)
            begin
                accepted_reg <= calc.ok;
                if (calc.ok)
                begin
                    corner_reg <= calc.coords;
                    angle_reg  <= b_angle_reg;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign angle_now      = angle_reg;
    assign top_left_x     = corner_reg[0];
    assign top_left_y     = corner_reg[1];
    assign top_right_x    = corner_reg[2];
    assign top_right_y    = corner_reg[3];
    assign bottom_left_x  = corner_reg[4];
    assign bottom_left_y  = corner_reg[5];
    assign bottom_right_x = corner_reg[6];
    assign bottom_right_y = corner_reg[7];

endmodule

`default_nettype wire
